### sv/fpgoc_pkg.sv
`default_nettype none

package fpgoc_pkg;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int SET_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 8;
    localparam int OUT_DW   = 40;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADJUSTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IN_WINDOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_MAX_WIN_LO = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_WIN_HI = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MIN_WIN_LO = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MIN_WIN_HI = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OFS_LIMIT  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_START_GAIN = 3'd5;
    localparam logic [CFG_AW-1:0] REG_START_OFS  = 3'd6;

    // Register reset values
    localparam logic [SET_W-1:0] RST_MAX_WIN_LO = 8'd180;
    localparam logic [SET_W-1:0] RST_MAX_WIN_HI = 8'd230;
    localparam logic [SET_W-1:0] RST_MIN_WIN_LO = 8'd20;
    localparam logic [SET_W-1:0] RST_MIN_WIN_HI = 8'd100;
    localparam logic [SET_W-1:0] RST_OFS_LIMIT  = 8'h14;
    localparam logic [SET_W-1:0] RST_START_GAIN = 8'h00;
    localparam logic [SET_W-1:0] RST_START_OFS  = 8'h00;

    // Running statistics reset values
    localparam logic [PIX_W-1:0] PIX_ALL_ONES = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO     = 8'h00;

    typedef struct packed {
        logic [SET_W-1:0] max_win_lo;
        logic [SET_W-1:0] max_win_hi;
        logic [SET_W-1:0] min_win_lo;
        logic [SET_W-1:0] min_win_hi;
        logic [SET_W-1:0] ofs_limit;
        logic [SET_W-1:0] start_gain;
        logic [SET_W-1:0] start_ofs;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] frame_max;
        logic [PIX_W-1:0] frame_min;
    } t_frame_stats;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SET_W-1:0]    gain;
        logic [SET_W-1:0]    offset;
    } t_decision;

endpackage

`default_nettype wire

### sv/fpgoc_stats.sv
`default_nettype none

module fpgoc_stats
    import fpgoc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_consume,
    input  wire logic             i_last,
    input  wire logic [PIX_W-1:0] i_inv_pixel,
    output t_frame_stats          o_stats
);

    logic             r_first;
    logic [PIX_W-1:0] r_max;
    logic [PIX_W-1:0] r_min;
    logic [PIX_W-1:0] n_max;
    logic [PIX_W-1:0] n_min;

    // Fold the current pixel into the running extremes
    always_comb begin
        if (r_first) begin
            n_max = i_inv_pixel;
            n_min = i_inv_pixel;
        end else begin
            n_max = (i_inv_pixel > r_max) ? i_inv_pixel : r_max;
            n_min = (i_inv_pixel < r_min) ? i_inv_pixel : r_min;
        end
    end

    assign o_stats.frame_max = n_max;
    assign o_stats.frame_min = n_min;

    // Running state; a frame end opens a new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_max   <= PIX_ZERO;
            r_min   <= PIX_ALL_ONES;
        end else if (i_consume) begin
            if (i_last) begin
                r_first <= 1'b1;
                r_max   <= PIX_ZERO;
                r_min   <= PIX_ALL_ONES;
            end else begin
                r_first <= 1'b0;
                r_max   <= n_max;
                r_min   <= n_min;
            end
        end
    end

endmodule

`default_nettype wire

### sv/fpgoc_decide.sv
`default_nettype none

module fpgoc_decide
    import fpgoc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_consume,
    input  wire logic   i_last,
    input  wire logic   i_restart,
    input  wire t_cfg   i_cfg,
    input  wire t_frame_stats i_stats,
    output t_decision   o_dec
);

    logic [SET_W-1:0] r_gain;
    logic [SET_W-1:0] r_offset;
    logic [SET_W-1:0] base_gain;
    logic [SET_W-1:0] base_offset;
    logic             max_ok;
    logic             min_ok;

    // Restart reloads before the decision
    assign base_gain   = i_restart ? i_cfg.start_gain : r_gain;
    assign base_offset = i_restart ? i_cfg.start_ofs  : r_offset;

    assign max_ok = (i_stats.frame_max > i_cfg.max_win_lo) &&
                    (i_stats.frame_max < i_cfg.max_win_hi);
    assign min_ok = (i_stats.frame_min > i_cfg.min_win_lo) &&
                    (i_stats.frame_min < i_cfg.min_win_hi);

    // Report in window, else step offset, roll over into gain, or report exhausted
    always_comb begin
        o_dec.gain   = base_gain;
        o_dec.offset = base_offset;
        if (max_ok && min_ok) begin
            o_dec.status = ST_IN_WINDOW;
        end else if (base_offset >= i_cfg.ofs_limit) begin
            if (base_gain == '0) begin
                o_dec.status = ST_EXHAUSTED;
            end else begin
                o_dec.status = ST_ADJUSTED;
                o_dec.gain   = base_gain - SET_W'(1);
                o_dec.offset = '0;
            end
        end else begin
            o_dec.status = ST_ADJUSTED;
            o_dec.offset = base_offset + SET_W'(1);
        end
    end

    // Settings update on every item: reload only, or reload plus decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= RST_START_GAIN;
            r_offset <= RST_START_OFS;
        end else if (i_consume) begin
            if (i_last) begin
                r_gain   <= o_dec.gain;
                r_offset <= o_dec.offset;
            end else begin
                r_gain   <= base_gain;
                r_offset <= base_offset;
            end
        end
    end

endmodule

`default_nettype wire

### sv/frame_peak_gain_offset_calibrator_core.sv
// A frame-end item's result passes through the input register and then the result register onto o_m_tdata.
// Throughput: one pixel item per cycle, unless a frame-end item waits for room in the result register;
// the min/max and decision update between the input register and the result register is combinational.
// Reset (i_rst_n low, synchronous): registers take their documented values,
// gain and offset settings go to the start reset values, statistics restart.
`default_nettype none

module frame_peak_gain_offset_calibrator_core
    import fpgoc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Pixel stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [PIX_W-1:0]  i_s_tdata,   // [7:0] pixel
    input  wire logic              i_s_tlast,   // frame_end
    input  wire logic              i_s_tuser,   // restart
    // Result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_DW-1:0]      o_m_tdata,   // [1:0] status, [9:2] gain_now,
                                                // [17:10] offset_now, [25:18] frame_max,
                                                // [33:26] frame_min, [39:34] zero
    // Configuration writes
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata
);

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [PIX_W-1:0] r_in_inv;
    logic             r_in_last;
    logic             r_in_restart;
    logic             r_out_valid;
    t_decision        r_out_dec;
    t_frame_stats     r_out_stats;
    logic             n_in_valid;
    logic             n_out_valid;
    logic             s_accept;
    logic             consume;
    logic             out_load;
    t_frame_stats     stats;
    t_decision        dec;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_win_lo <= RST_MAX_WIN_LO;
            r_cfg.max_win_hi <= RST_MAX_WIN_HI;
            r_cfg.min_win_lo <= RST_MIN_WIN_LO;
            r_cfg.min_win_hi <= RST_MIN_WIN_HI;
            r_cfg.ofs_limit  <= RST_OFS_LIMIT;
            r_cfg.start_gain <= RST_START_GAIN;
            r_cfg.start_ofs  <= RST_START_OFS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MAX_WIN_LO: r_cfg.max_win_lo <= i_cfg_wdata;
                REG_MAX_WIN_HI: r_cfg.max_win_hi <= i_cfg_wdata;
                REG_MIN_WIN_LO: r_cfg.min_win_lo <= i_cfg_wdata;
                REG_MIN_WIN_HI: r_cfg.min_win_hi <= i_cfg_wdata;
                REG_OFS_LIMIT:  r_cfg.ofs_limit  <= i_cfg_wdata;
                REG_START_GAIN: r_cfg.start_gain <= i_cfg_wdata;
                REG_START_OFS:  r_cfg.start_ofs  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: a non-last item always moves on; a last item needs room in the result reg
    assign consume    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign out_load   = consume && r_in_last;
    assign o_s_tready = !r_in_valid || consume;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign n_in_valid  = s_accept ? 1'b1 : (consume ? 1'b0 : r_in_valid);
    assign n_out_valid = out_load ? 1'b1 : ((r_out_valid && i_m_tready) ? 1'b0 : r_out_valid);

    // Input register, pixel inverted on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_inv     <= PIX_ALL_ONES - i_s_tdata;
            r_in_last    <= i_s_tlast;
            r_in_restart <= i_s_tuser;
        end
    end

    fpgoc_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_consume   (consume),
        .i_last      (r_in_last),
        .i_inv_pixel (r_in_inv),
        .o_stats     (stats)
    );

    fpgoc_decide u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_last    (r_in_last),
        .i_restart (r_in_restart),
        .i_cfg     (r_cfg),
        .i_stats   (stats),
        .o_dec     (dec)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dec   <= dec;
            r_out_stats <= stats;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_stats.frame_min, r_out_stats.frame_max,
                         r_out_dec.offset, r_out_dec.gain, r_out_dec.status};

    // Checks
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_dec.status == ST_ADJUSTED || r_out_dec.status == ST_IN_WINDOW ||
                        r_out_dec.status == ST_EXHAUSTED))
        else $error("illegal status code");

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_stats.frame_max >= r_out_stats.frame_min))
        else $error("frame max below frame min");

    a_exhausted_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_dec.status == ST_EXHAUSTED) |-> (r_out_dec.gain == '0))
        else $error("exhausted with nonzero gain");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fpgoc_pkg::*;

    // Index past the end of the register list; writes to it must be ignored
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 800;
    localparam int NUM_PHASES   = 8;
    localparam int PAD_W        = OUT_DW - 4 * SET_W - STATUS_W;

    // Result item as it sits on o_m_tdata, lowest field last
    typedef struct packed {
        logic [PAD_W-1:0]    pad;
        logic [PIX_W-1:0]    frame_min;
        logic [PIX_W-1:0]    frame_max;
        logic [SET_W-1:0]    offset;
        logic [SET_W-1:0]    gain;
        logic [STATUS_W-1:0] status;
    } t_calib_result;

    // Calibration predictor and result checker
    class t_calib_scoreboard;
        t_cfg             regs;
        logic [SET_W-1:0] gain;
        logic [SET_W-1:0] offset;
        logic [PIX_W-1:0] run_max;
        logic [PIX_W-1:0] run_min;
        logic             frame_open;   // next pixel opens a new frame
        t_calib_result    expected_results[$];
        int               mismatches;

        function new();
            regs.max_win_lo = RST_MAX_WIN_LO;
            regs.max_win_hi = RST_MAX_WIN_HI;
            regs.min_win_lo = RST_MIN_WIN_LO;
            regs.min_win_hi = RST_MIN_WIN_HI;
            regs.ofs_limit  = RST_OFS_LIMIT;
            regs.start_gain = RST_START_GAIN;
            regs.start_ofs  = RST_START_OFS;
            gain       = regs.start_gain;
            offset     = regs.start_ofs;
            run_max    = PIX_ZERO;
            run_min    = PIX_ALL_ONES;
            frame_open = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
            case (addr)
                REG_MAX_WIN_LO: regs.max_win_lo = data;
                REG_MAX_WIN_HI: regs.max_win_hi = data;
                REG_MIN_WIN_LO: regs.min_win_lo = data;
                REG_MIN_WIN_HI: regs.min_win_hi = data;
                REG_OFS_LIMIT:  regs.ofs_limit  = data;
                REG_START_GAIN: regs.start_gain = data;
                REG_START_OFS:  regs.start_ofs  = data;
                default: ;
            endcase
        endfunction

        // Accepted pixel: update frame stats, decide on frame end
        function void note_pixel(logic [PIX_W-1:0] raw, logic last, logic restart);
            logic [PIX_W-1:0] inv;
            logic             max_ok;
            logic             min_ok;
            t_calib_result    res;
            inv = PIX_ALL_ONES - raw;
            if (restart) begin
                gain   = regs.start_gain;
                offset = regs.start_ofs;
            end
            if (frame_open) begin
                run_max    = inv;
                run_min    = inv;
                frame_open = 1'b0;
            end else begin
                if (inv > run_max) run_max = inv;
                if (inv < run_min) run_min = inv;
            end
            if (!last) return;

            max_ok = (run_max > regs.max_win_lo) && (run_max < regs.max_win_hi);
            min_ok = (run_min > regs.min_win_lo) && (run_min < regs.min_win_hi);
            res = '0;
            if (max_ok && min_ok) begin
                res.status = ST_IN_WINDOW;
            end else if (offset >= regs.ofs_limit) begin
                // at or above the limit: step gain down, or report exhaustion
                if (gain == '0) begin
                    res.status = ST_EXHAUSTED;
                end else begin
                    gain       = gain - 1'b1;
                    offset     = '0;
                    res.status = ST_ADJUSTED;
                end
            end else begin
                offset     = offset + 1'b1;
                res.status = ST_ADJUSTED;
            end
            res.gain      = gain;
            res.offset    = offset;
            res.frame_max = run_max;
            res.frame_min = run_min;
            expected_results.push_back(res);

            run_max    = PIX_ZERO;
            run_min    = PIX_ALL_ONES;
            frame_open = 1'b1;
        endfunction

        function void check_result(logic [OUT_DW-1:0] raw);
            t_calib_result got;
            t_calib_result want;
            got = raw;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result %h with nothing expected", raw);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.gain !== want.gain ||
                got.offset !== want.offset || got.frame_max !== want.frame_max ||
                got.frame_min !== want.frame_min || got.pad !== want.pad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected st %0d gain %0d ofs %0d max %0d min %0d pad %h",
                             want.status, want.gain, want.offset, want.frame_max,
                             want.frame_min, want.pad);
                    $display("          got      st %0d gain %0d ofs %0d max %0d min %0d pad %h",
                             got.status, got.gain, got.offset, got.frame_max,
                             got.frame_min, got.pad);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [PIX_W-1:0]  i_s_tdata;   // [7:0] pixel
    logic              i_s_tlast;   // frame_end
    logic              i_s_tuser;   // restart
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_tdata;   // [1:0] status, [9:2] gain_now, [17:10] offset_now,
                                    // [25:18] frame_max, [33:26] frame_min, [39:34] zero
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;

    t_calib_scoreboard sb = new();
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                items_sent     = 0;
    int                quiet_cycles   = 0;

    frame_peak_gain_offset_calibrator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_pixel(i_s_tdata, i_s_tlast, i_s_tuser);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] raw, input logic last,
                              input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        i_s_tlast  <= last;
        i_s_tuser  <= restart;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // One frame; aimed frames keep their peaks near the windows
    task automatic send_frame(input int len, input bit aimed, input bit close);
        int               k;
        int               top;
        int               bot;
        int               tmp;
        logic [PIX_W-1:0] inv;
        top = $urandom_range(sb.regs.max_win_lo, sb.regs.max_win_hi);
        bot = $urandom_range(sb.regs.min_win_lo, sb.regs.min_win_hi);
        if (bot > top) begin
            tmp = top;
            top = bot;
            bot = tmp;
        end
        for (k = 0; k < len; k++) begin
            if (!aimed) inv = PIX_W'($urandom_range(255));
            else if (k == 0) inv = PIX_W'(top);
            else if (k == 1) inv = PIX_W'(bot);
            else inv = PIX_W'($urandom_range(bot, top));
            send_pixel(PIX_ALL_ONES - inv, close && (k == len - 1), $urandom_range(15) == 0);
        end
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(addr, data);
    endtask

    // Drain all expected results, then let the pipeline settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic program_phase(input int ph);
        t_cfg c;
        int   hi;
        if (ph == 1) begin
            c = '0;
        end else if (ph == 2) begin
            c = '1;
        end else begin
            c.max_win_lo = SET_W'($urandom_range(120, 220));
            hi = c.max_win_lo + $urandom_range(2, 35);
            c.max_win_hi = (hi > 255) ? 8'd255 : SET_W'(hi);
            c.min_win_lo = SET_W'($urandom_range(0, 80));
            c.min_win_hi = SET_W'(c.min_win_lo + $urandom_range(2, 60));
            c.ofs_limit  = SET_W'($urandom_range(0, 5));
            c.start_gain = SET_W'($urandom_range(0, 4));
            c.start_ofs  = SET_W'($urandom_range(0, 7));
        end
        write_reg(REG_MAX_WIN_LO, c.max_win_lo);
        write_reg(REG_MAX_WIN_HI, c.max_win_hi);
        write_reg(REG_MIN_WIN_LO, c.min_win_lo);
        write_reg(REG_MIN_WIN_HI, c.min_win_hi);
        write_reg(REG_OFS_LIMIT, c.ofs_limit);
        write_reg(REG_START_GAIN, c.start_gain);
        write_reg(REG_START_OFS, c.start_ofs);
        write_reg(REG_UNUSED, CFG_DW'($urandom_range(255)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_s_tuser   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: single-pixel extremes and each window edge
        send_pixel(8'd0, 1'b1, 1'b0);       // single pixel, inverted 255
        send_pixel(8'd255, 1'b1, 1'b0);     // single pixel, inverted 0
        send_pixel(8'd55, 1'b0, 1'b0);      // max 200, min 50: in window
        send_pixel(8'd205, 1'b1, 1'b0);
        send_pixel(8'd75, 1'b0, 1'b0);      // max on its low bound
        send_pixel(8'd205, 1'b1, 1'b0);
        send_pixel(8'd25, 1'b0, 1'b0);      // max on its high bound
        send_pixel(8'd205, 1'b1, 1'b0);
        send_pixel(8'd55, 1'b0, 1'b0);      // min on its low bound
        send_pixel(8'd235, 1'b1, 1'b0);
        send_pixel(8'd55, 1'b0, 1'b0);      // min on its high bound
        send_pixel(8'd155, 1'b1, 1'b0);
        wait_idle();

        // Start offset above the limit, gain one step from exhaustion
        write_reg(REG_OFS_LIMIT, 8'd1);
        write_reg(REG_START_GAIN, 8'd1);
        write_reg(REG_START_OFS, 8'd250);
        i_cfg_we <= 1'b0;
        send_pixel(8'd0, 1'b1, 1'b1);       // restart on frame end: reload, then decide
        send_pixel(8'd0, 1'b1, 1'b0);       // offset steps up
        send_pixel(8'd0, 1'b1, 1'b0);       // at limit with gain zero: exhausted
        send_pixel(8'd100, 1'b0, 1'b1);     // restart inside a frame
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        wait_idle();

        // Random phases: each programs its own settings and uses one of four idling patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            int phase_start;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            program_phase(ph);
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / NUM_PHASES) begin
                send_frame(($urandom_range(9) == 0) ? $urandom_range(7, 40) :
                           $urandom_range(1, 6), $urandom_range(9) < 6, 1'b1);
            end
            // sometimes leave a frame open across the settings change
            if ($urandom_range(2) == 0) send_frame($urandom_range(1, 4), 1'b0, 1'b0);
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/fpgoc_pkg.sv
sv/fpgoc_stats.sv
sv/fpgoc_decide.sv
sv/frame_peak_gain_offset_calibrator_core.sv
test/tb_top.sv
